// File: hw/rtl/cdq_pkg.sv
// cdq_pkg: shared widths, codes and types of the circular deque with key query
// used by the channel interfaces, the controller, the datapath and the top level
package cdq_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned COST_W   = 20;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 24;
  localparam int unsigned FILL_W   = 5;

  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_QUERY      = 3'd4,
    MODE_TOTAL      = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue_rd;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic last_rd;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/cdq_in_if.sv
// cdq_in_if: input channel with valid/ready and one command item
// depends on cdq_pkg for field widths
interface cdq_in_if import cdq_pkg::*;;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  entry_key;
  logic [COST_W-1:0] entry_cost;

  modport source (output valid, output mode, output entry_key, output entry_cost,
                  input ready);
  modport sink   (input valid, input mode, input entry_key, input entry_cost,
                  output ready);

endinterface

// File: hw/rtl/cdq_out_if.sv
// cdq_out_if: result channel with valid/ready and one result item
// depends on cdq_pkg for field widths
interface cdq_out_if import cdq_pkg::*;;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                key_found;
  logic [TOTAL_W-1:0]  cost_total;
  logic [FILL_W-1:0]   fill_level;

  modport source (output valid, output status, output key_found, output cost_total,
                  output fill_level, input ready);
  modport sink   (input valid, input status, input key_found, input cost_total,
                  input fill_level, output ready);

endinterface

// File: hw/rtl/cdq_ctrl.sv
// cdq_ctrl: sequencer of the deque, one item at a time: accept, scan, commit
// depends on cdq_pkg for state, command and status types
module cdq_ctrl import cdq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (status_i.last_rd) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.issue_rd = 1'b1;
      end
      S_DRAIN: begin
      end
      S_FINISH: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/cdq_dp.sv
// cdq_dp: entry memories, head/tail/count registers, scan accumulators
// and the result register; depends on cdq_pkg and cdq_out_if
module cdq_dp import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [KEY_W-1:0]  entry_key_i,
  input  logic [COST_W-1:0] entry_cost_i,
  input  dp_cmd_t           cmd_i,
  output dp_status_t        status_o,
  cdq_out_if.source         out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [KEY_W-1:0]  key_mem  [DEPTH];
  logic [COST_W-1:0] cost_mem [DEPTH];

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d, rem_q, rem_d;

  mode_e             mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [COST_W-1:0] cost_q;

  logic              rd_vld_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic [COST_W-1:0] rd_cost_q;

  logic               found_q, found_d;
  logic [TOTAL_W-1:0] acc_q, acc_d;
  logic [TOTAL_W:0]   sum;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  status_e            stat;

  logic                out_vld_q, out_vld_d;
  logic [STATUS_W-1:0] out_status_q;
  logic                out_found_q;
  logic [TOTAL_W-1:0]  out_total_q;
  logic [FILL_W-1:0]   out_fill_q;

  logic full, empty;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  assign full  = (cnt_q == FULL_CNT);
  assign empty = (cnt_q == '0);

  assign status_o.need_scan = ((mode_i == MODE_QUERY) || (mode_i == MODE_TOTAL)) && !empty;
  assign status_o.last_rd   = (rem_q == CW'(1));
  assign status_o.out_free  = !out_vld_q || out_o.ready;

  // item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= entry_key_i;
      cost_q <= entry_cost_i;
    end
  end

  // scan walk
  always_comb begin
    ptr_d = ptr_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      ptr_d = head_q;
      rem_d = status_o.need_scan ? cnt_q : '0;
    end else if (cmd_i.issue_rd) begin
      ptr_d = step_up(ptr_q);
      rem_d = rem_q - CW'(1);
    end
  end

  // scan accumulators
  assign sum = {1'b0, acc_q} + (TOTAL_W + 1)'(rd_cost_q);

  always_comb begin
    found_d = found_q;
    acc_d   = acc_q;
    if (cmd_i.load) begin
      found_d = 1'b0;
      acc_d   = '0;
    end else if (rd_vld_q) begin
      if (mode_q == MODE_QUERY) begin
        found_d = found_q | (rd_key_q == key_q);
      end else begin
        acc_d = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end
    end
  end

  // commit of the deque update
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_addr = tail_q;
    stat    = STAT_OK;
    unique case (mode_q)
      MODE_PUSH_BACK: begin
        if (full) begin
          stat = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = tail_q;
          tail_d  = step_up(tail_q);
          cnt_d   = cnt_q + CW'(1);
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          stat = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          head_d  = step_down(head_q);
          wr_addr = head_d;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          stat = STAT_EMPTY;
        end else begin
          head_d = step_up(head_q);
          cnt_d  = cnt_q - CW'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          stat = STAT_EMPTY;
        end else begin
          tail_d = step_down(tail_q);
          cnt_d  = cnt_q - CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (!cmd_i.commit) begin
      head_d = head_q;
      tail_d = tail_q;
      cnt_d  = cnt_q;
      wr_en  = 1'b0;
    end
  end

  // entry memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= key_q;
      cost_mem[wr_addr] <= cost_q;
    end
    if (cmd_i.issue_rd) begin
      rd_key_q  <= key_mem[ptr_q];
      rd_cost_q <= cost_mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      ptr_q     <= '0;
      rem_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      ptr_q     <= ptr_d;
      rem_q     <= rem_d;
      rd_vld_q  <= cmd_i.issue_rd;
      found_q   <= found_d;
      acc_q     <= acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.commit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= stat;
      out_found_q  <= (mode_q == MODE_QUERY) ? found_q : 1'b0;
      out_total_q  <= (mode_q == MODE_TOTAL) ? acc_q : '0;
      out_fill_q   <= FILL_W'(cnt_d);
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_status_q;
  assign out_o.key_found  = out_found_q;
  assign out_o.cost_total = out_total_q;
  assign out_o.fill_level = out_fill_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("entry count above depth");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_vld_q || out_o.ready))
    else $error("result overwritten before transfer");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue_rd |-> (rem_q != '0))
    else $error("read issued past stored entries");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(cnt_q))
    else $error("count changed without commit");
`endif

endmodule

// File: hw/rtl/circular_deque_with_key_query_top.sv
// circular_deque_with_key_query_top: deque of key/cost entries with query and total
// depends on cdq_pkg, cdq_in_if, cdq_out_if, cdq_ctrl and cdq_dp
//
//   port   dir  handshake     payload
//   in_i   in   valid/ready   mode, entry_key, entry_cost
//   out_o  out  valid/ready   status, key_found, cost_total, fill_level
//
// push, pop, unused modes and query or total on an empty deque go from the input
// transfer straight to commit; query and total otherwise first read every stored entry
// the next input can be taken from the cycle after the result register is written
// reset clears head, tail, count and valid flags; entry memories are not cleared
// a waiting result sits in the output register while the next item is taken
// and processed; the block stalls at commit until that result is transferred
module circular_deque_with_key_query_top import cdq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cdq_in_if.sink   in_i,
  cdq_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_i.ready = in_ready;

  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (in_i.mode),
    .entry_key_i  (in_i.entry_key),
    .entry_cost_i (in_i.entry_cost),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_o        (out_o)
  );

endmodule
